// ===== hw/rtl/sample_clock_drift_tracker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sample clock drift tracker: assertion macros
// Shared concurrent-assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_CLOCK_DRIFT_TRACKER_UNIT_DEFINES_SVH
`define SAMPLE_CLOCK_DRIFT_TRACKER_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SCDT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SCDT_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (nxt)) else $error(msg);

`endif

// ===== hw/rtl/scdt_pkg.sv =====
// ----------------------------------------------------------------------------
// scdt_pkg
// Widths, register indexes, reset values and controller states of the
// sample clock drift tracker.
// ----------------------------------------------------------------------------
package scdt_pkg;

    localparam int POSITION_BITS = 48;
    localparam int FRACTION_BITS = 32;

    localparam int TIME_W    = 64;
    localparam int POS_W     = 48;
    localparam int RATE_W    = 20;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 20;

    localparam int IN_DATA_W  = POS_W + TIME_W;
    localparam int OUT_DATA_W = TIME_W;

    localparam int DIV_STEPS = POSITION_BITS + FRACTION_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int MUL_CNT_W = $clog2(GAIN_W);
    localparam int PROD_W    = TIME_W + GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEWHEEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_GAIN  = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RST = 20'd48000;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd655;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_RESET  = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_SUM  = 8'b0000_0100,
        ST_DIFF = 8'b0000_1000,
        ST_ABS  = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_CORR = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } t_state;

endpackage

// ===== hw/rtl/sample_clock_drift_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// sample_clock_drift_tracker_unit
// Turns an audio sample position into 32.32 seconds and tracks the wall
// clock with a first-order low-pass correction of the time base.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   tuser: kind; tdata: sample_position, wall_time
// m_axis    out  tdata: ntp_time
// cfg       in   we / idx / wdata: sample_rate, freewheel, drift_gain
//
// Update words pass through 80 restoring divider steps (one quotient bit
// each), 16 shift-add gain steps and 5 control steps to the output register;
// reset and freewheel words skip the correction.
// One word is in work at a time; the next is taken once the result sits in
// the output register, even if the consumer stalls it there.
// Synchronous active-low reset clears the base time and loads the defaults.
// ----------------------------------------------------------------------------
module sample_clock_drift_tracker_unit
    import scdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [47:0] sample_position, [111:48] wall_time
    input  logic                  i_s_axis_tuser,  // [0] kind
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // [63:0] ntp_time
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;
    logic [TIME_W-1:0]        r_base, n_base;
    logic [RATE_W-1:0]        r_rate;
    logic                     r_fw;
    logic [GAIN_W-1:0]        r_gain;

    logic [TIME_W-1:0]        r_out_data, n_out_data;
    logic                     r_kind, n_kind;
    logic [TIME_W-1:0]        r_wall, n_wall;
    logic [POSITION_BITS-1:0] r_dvd, n_dvd;
    logic [RATE_W-1:0]        r_rem, n_rem;
    logic [TIME_W-1:0]        r_quo, n_quo;
    logic [TIME_W-1:0]        r_sum, n_sum;
    logic [TIME_W-1:0]        r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic [PROD_W-1:0]        r_prod, n_prod;

    logic [RATE_W-1:0]        w_rate_eff;
    logic [RATE_W:0]          w_trial;
    logic [RATE_W:0]          w_trial_sub;
    logic [TIME_W-1:0]        w_diff;
    logic [MUL_CNT_W-1:0]     w_gidx;
    logic [TIME_W-1:0]        w_q;
    logic                     w_frac_nz;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_rate_eff  = (r_rate == '0) ? RATE_W'(1) : r_rate;
    assign w_trial     = {r_rem, r_dvd[POSITION_BITS-1]};
    assign w_trial_sub = w_trial - {1'b0, w_rate_eff};
    assign w_diff      = r_wall - r_sum;
    assign w_gidx      = MUL_CNT_W'(GAIN_W - 1) - r_cnt[MUL_CNT_W-1:0];
    assign w_q         = r_prod[PROD_W-1:GAIN_W];
    assign w_frac_nz   = |r_prod[GAIN_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_base      = r_base;
        n_kind      = r_kind;
        n_wall      = r_wall;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_sum       = r_sum;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_prod      = r_prod;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind  = i_s_axis_tuser;
                    n_dvd   = POSITION_BITS'(i_s_axis_tdata[POS_W-1:0]);
                    n_wall  = i_s_axis_tdata[IN_DATA_W-1:POS_W];
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // one restoring step: bring down a dividend bit, subtract if it fits
                if (!w_trial_sub[RATE_W]) begin
                    n_rem = w_trial_sub[RATE_W-1:0];
                end else begin
                    n_rem = w_trial[RATE_W-1:0];
                end
                n_quo = {r_quo[TIME_W-2:0], ~w_trial_sub[RATE_W]};
                n_dvd = {r_dvd[POSITION_BITS-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_kind == KIND_RESET) begin
                    n_base  = r_wall - r_quo;
                    n_state = ST_FIN;
                end else if (r_fw) begin
                    n_state = ST_FIN;
                end else begin
                    n_sum   = r_base + r_quo;
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_mag   = w_diff;
                n_neg   = w_diff[TIME_W-1];
                n_state = ST_ABS;
            end
            ST_ABS: begin
                if (r_neg) begin
                    n_mag = ~r_mag + TIME_W'(1);
                end
                n_prod  = '0;
                n_cnt   = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                // shift-add over the gain bits, most significant first
                n_prod = {r_prod[PROD_W-2:0], 1'b0}
                       + (r_gain[w_gidx] ? PROD_W'(r_mag) : PROD_W'(0));
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt[MUL_CNT_W-1:0] == MUL_CNT_W'(GAIN_W - 1)) begin
                    n_state = ST_CORR;
                end
            end
            ST_CORR: begin
                // negative drift: base - ceil-adjusted q equals base + ~q + (frac == 0)
                if (r_neg) begin
                    n_base = r_base + ~w_q + TIME_W'(!w_frac_nz);
                end else begin
                    n_base = r_base + w_q;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_data  = r_base + r_quo;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_rate      <= RATE_RST;
            r_fw        <= 1'b0;
            r_gain      <= GAIN_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_base      <= n_base;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SAMPLE_RATE: r_rate <= i_cfg_wdata[RATE_W-1:0];
                    CFG_FREEWHEEL:   r_fw   <= i_cfg_wdata[0];
                    CFG_DRIFT_GAIN:  r_gain <= i_cfg_wdata[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_kind     <= n_kind;
        r_wall     <= n_wall;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_sum      <= n_sum;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
    end

endmodule

// ===== hw/rtl/scdt_checker.sv =====
// ----------------------------------------------------------------------------
// scdt_checker
// Port-level checks of the sample clock drift tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "sample_clock_drift_tracker_unit_defines.svh"

module scdt_checker
    import scdt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [47:0] sample_position, [111:48] wall_time
    input logic                  i_s_axis_tuser,  // [0] kind
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // [63:0] ntp_time
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_W-1:0]      i_cfg_wdata
);

    logic w_in_acc;
    logic w_busy;
    logic w_out_stall;

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_busy      = !o_s_axis_tready;
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // one word in work at a time
    `SCDT_ASSERT_NEXT(a_one_in_flight, w_in_acc, !o_s_axis_tready, "input taken twice")
    // a result never shows up the cycle after an input is taken
    `SCDT_ASSERT_NEXT(a_no_early_result, w_in_acc, !$rose(o_m_axis_tvalid), "result too early")
    // a new result only comes from a word in work
    `SCDT_ASSERT(a_result_from_work, $rose(o_m_axis_tvalid) |-> $past(w_busy), "result from idle")
    // stalled result stays valid and holds its data
    `SCDT_ASSERT_NEXT(a_out_keep, w_out_stall, o_m_axis_tvalid, "stalled result dropped")
    `SCDT_ASSERT_NEXT(a_out_hold, w_out_stall, $stable(o_m_axis_tdata), "stalled result changed")

endmodule

bind sample_clock_drift_tracker_unit scdt_checker u_scdt_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: sample clock drift tracker testbench
// Streams update and reset words with random gaps into the tracker and
// predicts each corrected timestamp from its own copy of the time base
// and registers. Covers register extremes, freewheel, zero rate, random
// tracking runs, noise and a long output stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scdt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 110;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]      cfg_wdata;

    sample_clock_drift_tracker_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Predicted tracker state and registers
    logic [TIME_W-1:0] base_track;
    logic [RATE_W-1:0] rate_track;
    logic              freewheel_track;
    logic [GAIN_W-1:0] gain_track;

    logic [TIME_W-1:0] ntp_expected[$];
    int                mismatches;
    int                next_gap;
    bit                offering;
    bit                no_idle;
    bit                tight_send;
    int                hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [POS_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[POS_W-1:0];
    endfunction

    // position / rate in fixed-point seconds, wrapped to 64 bits
    function automatic logic [TIME_W-1:0] sample_offset(input logic [POS_W-1:0] pos);
        logic [POS_W+FRACTION_BITS-1:0] num;
        logic [POS_W+FRACTION_BITS-1:0] quo;
        logic [RATE_W-1:0]              rate;
        rate = (rate_track == '0) ? RATE_W'(1) : rate_track;
        num  = {pos, {FRACTION_BITS{1'b0}}};
        quo  = num / rate;
        return quo[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] predict_ntp(input logic kind,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [TIME_W-1:0] wall);
        logic [TIME_W-1:0] offs;
        logic [TIME_W-1:0] drift;
        logic signed [80:0] prod;
        logic signed [80:0] corr;
        offs = sample_offset(pos);
        if (kind == KIND_RESET) begin
            base_track = wall - offs;
            return wall;
        end
        if (freewheel_track)
            return base_track + offs;
        drift = wall - (base_track + offs);
        prod = $signed({{17{drift[63]}}, drift}) * $signed({65'd0, gain_track});
        // arithmetic shift floors toward minus infinity
        corr = prod >>> 16;
        base_track = base_track + corr[TIME_W-1:0];
        return base_track + offs;
    endfunction

    task automatic send_item(input logic kind, input logic [POS_W-1:0] pos,
                             input logic [TIME_W-1:0] wall);
        if (!offering)
            repeat (next_gap) @(posedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {wall, pos};
        offering = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        ntp_expected.push_back(predict_ntp(kind, pos, wall));
        next_gap = (no_idle || tight_send) ? 0 : $urandom_range(0, 4);
        // keep valid up when the next word follows back to back
        if (next_gap != 0) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic wait_idle();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (ntp_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SAMPLE_RATE: rate_track = val[RATE_W-1:0];
            CFG_FREEWHEEL:   freewheel_track = val[0];
            CFG_DRIFT_GAIN:  gain_track = val[GAIN_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly anchored tracking runs with jittered wall clock, some noise
    task automatic run_stream(input int n);
        int                sent;
        int                len;
        int                k;
        logic [POS_W-1:0]  p0;
        logic [POS_W-1:0]  p;
        logic [TIME_W-1:0] w0;
        logic [TIME_W-1:0] jit;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(4, 20);
                p0  = rand48() >> $urandom_range(0, 47);
                w0  = rand64();
                send_item(KIND_RESET, p0, w0);
                sent++;
                p = p0;
                for (k = 0; k < len; k++) begin
                    p   = p + POS_W'($urandom_range(64, 2048));
                    jit = rand64() >> $urandom_range(8, 63);
                    if ($urandom_range(0, 1) == 1)
                        jit = -jit;
                    if ($urandom_range(0, 15) == 0)
                        send_item(KIND_RESET, p, rand64());
                    else
                        send_item(KIND_UPDATE, p,
                                  w0 + sample_offset(p) - sample_offset(p0) + jit);
                    sent++;
                end
            end else begin
                send_item(1'($urandom_range(0, 1)), rand48(), rand64());
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        // defaults after reset, base at zero
        send_item(KIND_UPDATE, '0, '0);
        send_item(KIND_UPDATE, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_UPDATE, '0, 64'h8000_0000_0000_0000);
        send_item(KIND_UPDATE, '0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_UPDATE, 48'd48000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_RESET, 48'hFFFF_FFFF_FFFF, '0);
        send_item(KIND_RESET, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_UPDATE, 48'd1, 64'd1);
        wait_idle();
        // zero rate acts as one
        write_reg(CFG_SAMPLE_RATE, '0);
        send_item(KIND_UPDATE, 48'hFFFF_FFFF_FFFF, '0);
        send_item(KIND_RESET, 48'd12345, 64'h0123_4567_89AB_CDEF);
        wait_idle();
        write_reg(CFG_SAMPLE_RATE, 20'hFFFFF);
        write_reg(CFG_FREEWHEEL, 20'hFFFFF);
        send_item(KIND_UPDATE, 48'h8000_0000_0000, 64'h5555_5555_5555_5555);
        send_item(KIND_RESET, 48'd777, 64'hDEAD_BEEF_CAFE_F00D);
        send_item(KIND_UPDATE, 48'd778, '0);
        wait_idle();
        write_reg(CFG_FREEWHEEL, 20'hFFFFE);
        write_reg(CFG_DRIFT_GAIN, 20'hF0000);
        send_item(KIND_UPDATE, 48'd1000, 64'hFFFF_0000_0000_0000);
        send_item(KIND_UPDATE, 48'd2000, 64'h0000_FFFF_0000_0000);
        wait_idle();
        write_reg(CFG_DRIFT_GAIN, 20'h0FFFF);
        send_item(KIND_UPDATE, 48'd3000, 64'h8000_0000_0000_0000);
        send_item(KIND_UPDATE, 48'd3001, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_UPDATE, 48'd3002, '0);
        wait_idle();
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        write_reg(CFG_SAMPLE_RATE, 20'd1000);
        send_item(KIND_UPDATE, 48'd999, 64'd12345);
        send_item(KIND_UPDATE, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_settings_sweep();
        int                p;
        logic [RATE_W-1:0] rate;
        logic [GAIN_W-1:0] gain;
        for (p = 0; p < 10; p++) begin
            case (p % 7)
                0: rate = 20'd48000;
                1: rate = 20'd1000;
                2: rate = 20'd768000;
                3: rate = 20'd1;
                4: rate = 20'hFFFFF;
                5: rate = 20'd44100;
                default: rate = RATE_W'($urandom_range(1000, 768000));
            endcase
            case (p % 6)
                0: gain = 16'd655;
                1: gain = 16'hFFFF;
                2: gain = '0;
                3: gain = 16'd1;
                4: gain = 16'h8000;
                default: gain = GAIN_W'($urandom);
            endcase
            wait_idle();
            write_reg(CFG_SAMPLE_RATE, CFG_W'(rate));
            write_reg(CFG_DRIFT_GAIN, {4'($urandom), gain});
            write_reg(CFG_FREEWHEEL, {19'($urandom), 1'(p % 4 == 3)});
            if (p % 3 == 0)
                write_reg(CFG_UNUSED, CFG_W'($urandom));
            run_stream(120);
        end
        wait_idle();
    endtask

    task automatic test_no_gaps();
        wait_idle();
        write_reg(CFG_SAMPLE_RATE, 20'd96000);
        write_reg(CFG_FREEWHEEL, '0);
        write_reg(CFG_DRIFT_GAIN, 20'd2000);
        no_idle = 1'b1;
        run_stream(100);
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        int k;
        wait_idle();
        hold_cycles = 600;
        tight_send  = 1'b1;
        for (k = 0; k < 12; k++)
            send_item(1'($urandom_range(0, 1)), rand48(), rand64());
        tight_send = 1'b0;
        wait_idle();
    endtask

    // Receiver: random stall per word, long hold-off on request
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (ntp_expected.size() == 0) begin
                $display("%0t: unexpected ntp_time word %h", $time, m_tdata);
                mismatches++;
            end else begin
                if (m_tdata !== ntp_expected[0]) begin
                    $display("%0t: ntp_time expected %h actual %h",
                             $time, ntp_expected[0], m_tdata);
                    mismatches++;
                end
                void'(ntp_expected.pop_front());
            end
        end
    end

    initial begin
        i_rst_n   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= '0;
        cfg_wdata <= '0;
        base_track      = '0;
        rate_track      = RATE_RST;
        freewheel_track = 1'b0;
        gain_track      = GAIN_RST;
        mismatches  = 0;
        next_gap    = 0;
        offering    = 1'b0;
        no_idle     = 1'b0;
        tight_send  = 1'b0;
        hold_cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_settings_sweep();
        test_output_stall();
        test_no_gaps();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ntp_expected.size() != 0) begin
            $display("%0t: %0d ntp_time words never arrived", $time, ntp_expected.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sample_clock_drift_tracker_unit.f =====
+incdir+hw/rtl
hw/rtl/scdt_pkg.sv
hw/rtl/sample_clock_drift_tracker_unit.sv
hw/rtl/scdt_checker.sv
bench/tb.sv
